/* rtl/kmer_decimal_hash_encoder_assert.svh */
// Assertion macros shared by the k-mer hash encoder modules.
`ifndef KMER_DECIMAL_HASH_ENCODER_ASSERT_SVH
`define KMER_DECIMAL_HASH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KDH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kdh_pkg.sv */
// Types, constants and digit tables for the k-mer decimal hash encoder.
`default_nettype none

package kdh_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } kdh_in_t;

  typedef struct packed {
    logic [63:0] forward_hash;
    logic [63:0] revcomp_hash;
    logic        overflowed;
    logic [4:0]  bases_used;
  } kdh_out_t;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  localparam logic [2:0] DIGIT_A = 3'd1;
  localparam logic [2:0] DIGIT_C = 3'd2;
  localparam logic [2:0] DIGIT_G = 3'd3;
  localparam logic [2:0] DIGIT_T = 3'd4;
  localparam logic [2:0] DIGIT_N = 3'd5;

  // Entries in the power-of-ten table; also the hard limit on bases.
  localparam logic [4:0] POW_DEPTH        = 5'd20;
  localparam logic [4:0] LENGTH_CAP_RESET = 5'd20;

  function automatic logic [2:0] base_digit(input logic [7:0] sym);
    logic [2:0] d;
    case (sym)
      SYM_A:   d = DIGIT_A;
      SYM_C:   d = DIGIT_C;
      SYM_G:   d = DIGIT_G;
      SYM_T:   d = DIGIT_T;
      default: d = DIGIT_N;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] comp_digit(input logic [7:0] sym);
    logic [2:0] d;
    case (sym)
      SYM_A:   d = DIGIT_T;
      SYM_C:   d = DIGIT_G;
      SYM_G:   d = DIGIT_C;
      SYM_T:   d = DIGIT_A;
      default: d = DIGIT_N;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] pow10(input logic [4:0] idx);
    logic [63:0] p;
    case (idx)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/kdh_in_stage.sv */
// Input register stage: holds one request until the hash stage takes it.
`default_nettype none

`include "kmer_decimal_hash_encoder_assert.svh"

module kdh_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kdh_pkg::kdh_in_t  in_data,
  input  wire logic              advance,
  output logic                   s1_valid,
  output kdh_pkg::kdh_in_t       s1_data
);

  logic             s1_v_r;
  logic             s1_v_nxt;
  kdh_pkg::kdh_in_t s1_d_r;
  logic             accept;

  assign in_ready = !s1_v_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_d_r <= in_data;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_d_r;

  `KDH_ASSERT_NOW(a_adv_needs_item, clk, rst_n, advance, s1_v_r,
                  "advance without a held request")
  `KDH_ASSERT_NEXT(a_held_on_stall, clk, rst_n, s1_v_r && !advance,
                   s1_v_r && $stable(s1_d_r), "held request lost while stalled")

endmodule

`default_nettype wire

/* rtl/kdh_core.sv */
// Hash stage: per-base accumulator update and the result register.
`default_nettype none

`include "kmer_decimal_hash_encoder_assert.svh"

module kdh_core #(
  parameter int MAX_BASES = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [4:0]        length_cap,
  input  wire logic              s1_valid,
  input  wire kdh_pkg::kdh_in_t  s1_data,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kdh_pkg::kdh_out_t      out_data
);

  localparam logic [4:0] MAX_CAP = 5'(MAX_BASES);

  logic [63:0]       fwd_r, fwd_nxt;
  logic [63:0]       rev_r, rev_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_v_r, out_v_nxt;
  kdh_pkg::kdh_out_t out_r;

  logic [4:0]  cap_eff;
  logic        take;
  logic        finish;
  logic [2:0]  dig;
  logic [2:0]  cdig;
  logic [67:0] fwd_sum;
  logic [66:0] prod;
  logic [64:0] rev_sum;
  logic        step_ovf;

  assign cap_eff = (length_cap > MAX_CAP) ? MAX_CAP : length_cap;
  assign take    = (cnt_r < cap_eff) && (cnt_r < kdh_pkg::POW_DEPTH);

  // Result register frees up this cycle, or the request makes no result.
  assign advance = s1_valid && (!s1_data.last || !out_v_r || out_ready);
  assign finish  = advance && s1_data.last;

  assign dig  = kdh_pkg::base_digit(s1_data.symbol);
  assign cdig = kdh_pkg::comp_digit(s1_data.symbol);

  // x*10 + d as two shifts and adds, kept wide to see the carry out
  assign fwd_sum = ({4'd0, fwd_r} << 3) + ({4'd0, fwd_r} << 1) + {65'd0, dig};
  assign prod    = {3'd0, kdh_pkg::pow10(cnt_r)} * {64'd0, cdig};
  assign rev_sum = {1'b0, rev_r} + {1'b0, prod[63:0]};
  assign step_ovf = (|fwd_sum[67:64]) || (|prod[66:64]) || rev_sum[64];

  always_comb begin
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (advance && take) begin
      fwd_nxt = fwd_sum[63:0];
      rev_nxt = rev_sum[63:0];
      cnt_nxt = 5'(cnt_r + 5'd1);
      ovf_nxt = ovf_r || step_ovf;
    end
  end

  always_comb begin
    if (finish) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r   <= '0;
      rev_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (finish) begin
        fwd_r <= '0;
        rev_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        fwd_r <= fwd_nxt;
        rev_r <= rev_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r.forward_hash <= fwd_nxt;
      out_r.revcomp_hash <= rev_nxt;
      out_r.overflowed   <= ovf_nxt;
      out_r.bases_used   <= cnt_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `KDH_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= kdh_pkg::POW_DEPTH,
                  "base count past table depth")
  `KDH_ASSERT_NOW(a_no_overwrite, clk, rst_n, finish, !out_v_r || out_ready,
                  "result register overwritten before it was taken")
  `KDH_ASSERT_NEXT(a_clear_on_last, clk, rst_n, finish,
                   out_v_r && cnt_r == 5'd0 && !ovf_r,
                   "sequence state not cleared after last base")

endmodule

`default_nettype wire

/* rtl/kmer_decimal_hash_encoder.sv */
// Result path: a last request is held in the input register, then its result
//   is loaded into the result register, which drives out_valid.
// Throughput: one request per cycle; a last request stalls only while the
//   result register is full and out_ready is low.
// Reset: synchronous active-low rst_n clears the pipeline valids and the
//   sequence state; length_cap returns to 20.
`default_nettype none

module kmer_decimal_hash_encoder #(
  parameter int MAX_BASES = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kdh_pkg::kdh_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kdh_pkg::kdh_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_wdata
);

  logic [4:0]       cap_r;
  logic             advance;
  logic             s1_valid;
  kdh_pkg::kdh_in_t s1_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= kdh_pkg::LENGTH_CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  kdh_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  kdh_core #(
    .MAX_BASES (MAX_BASES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .length_cap (cap_r),
    .s1_valid   (s1_valid),
    .s1_data    (s1_data),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
